/* rtl/evad_pkg.sv */
// ----------------------------------------------------------------------------
// evad_pkg
// Shared widths, register codes, reset values and channel structs of the
// energy voice activity detector with hangover gate.
// ----------------------------------------------------------------------------
package evad_pkg;

    localparam int MAX_FRAME_SAMPLES = 4096;

    localparam int SAMPLE_W    = 16;
    localparam int MAG_W       = SAMPLE_W + 1;
    localparam int SQ_W        = 2 * SAMPLE_W - 1;
    localparam int CNT_W       = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int ACC_W       = SQ_W - 1 + CNT_W;
    localparam int PTHR_W      = 31;
    localparam int HANG_W      = 10;
    localparam int PROB_W      = 8;
    localparam int PROD_W      = PTHR_W + CNT_W;
    localparam int ENERGY_W    = 43;
    localparam int COUNT_OUT_W = 13;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [ENERGY_W-1:0]    ENERGY_MAX    = '1;
    localparam logic [COUNT_OUT_W-1:0] COUNT_OUT_MAX = '1;

    localparam logic [PTHR_W-1:0] POWER_THRESHOLD_RST = PTHR_W'(10000);
    localparam logic [HANG_W-1:0] HANGOVER_FRAMES_RST = HANG_W'(10);
    localparam logic              USE_PROB_VAD_RST    = 1'b0;
    localparam logic [PROB_W-1:0] PROB_THRESHOLD_RST  = PROB_W'(128);

    typedef enum logic [ADDR_W-3:0] {
        REG_POWER_THRESHOLD = 2'd0,
        REG_HANGOVER_FRAMES = 2'd1,
        REG_USE_PROB_VAD    = 2'd2,
        REG_PROB_THRESHOLD  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [PTHR_W-1:0] power_threshold;
        logic [HANG_W-1:0] hangover_frames;
        logic              use_prob_vad;
        logic [PROB_W-1:0] prob_threshold;
    } t_cfg;

    typedef struct packed {
        logic [ACC_W-1:0]  energy;
        logic [CNT_W-1:0]  count;
        logic              prob_valid;
        logic [PROB_W-1:0] voice_prob;
    } t_frame;

    typedef struct packed {
        logic [ENERGY_W-1:0]    frame_energy;
        logic [COUNT_OUT_W-1:0] frame_count;
        logic                   voice_detected;
        logic                   speaking;
        logic                   speaking_changed;
        logic                   send_frame;
        logic                   send_silence;
    } t_result;

endpackage

/* rtl/evad_regs.sv */
// ----------------------------------------------------------------------------
// evad_regs
// APB register file holding the detector thresholds, the probability mode select and the hangover length.
// ----------------------------------------------------------------------------
module evad_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [evad_pkg::ADDR_W-1:0]   paddr,
    input  logic [evad_pkg::DATA_W-1:0]   pwdata,
    output logic [evad_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output evad_pkg::t_cfg                o_cfg
);

    evad_pkg::t_cfg   r_cfg;
    evad_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = evad_pkg::t_reg_idx'(paddr[evad_pkg::ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_threshold <= evad_pkg::POWER_THRESHOLD_RST;
            r_cfg.hangover_frames <= evad_pkg::HANGOVER_FRAMES_RST;
            r_cfg.use_prob_vad    <= evad_pkg::USE_PROB_VAD_RST;
            r_cfg.prob_threshold  <= evad_pkg::PROB_THRESHOLD_RST;
        end else if (w_wr) begin
            case (w_idx)
                evad_pkg::REG_POWER_THRESHOLD: begin
                    r_cfg.power_threshold <= pwdata[evad_pkg::PTHR_W-1:0];
                end
                evad_pkg::REG_HANGOVER_FRAMES: begin
                    r_cfg.hangover_frames <= pwdata[evad_pkg::HANG_W-1:0];
                end
                evad_pkg::REG_USE_PROB_VAD: begin
                    r_cfg.use_prob_vad <= pwdata[0];
                end
                evad_pkg::REG_PROB_THRESHOLD: begin
                    r_cfg.prob_threshold <= pwdata[evad_pkg::PROB_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            evad_pkg::REG_POWER_THRESHOLD: prdata = evad_pkg::DATA_W'(r_cfg.power_threshold);
            evad_pkg::REG_HANGOVER_FRAMES: prdata = evad_pkg::DATA_W'(r_cfg.hangover_frames);
            evad_pkg::REG_USE_PROB_VAD:    prdata = evad_pkg::DATA_W'(r_cfg.use_prob_vad);
            evad_pkg::REG_PROB_THRESHOLD:  prdata = evad_pkg::DATA_W'(r_cfg.prob_threshold);
            default:                       prdata = '0;
        endcase
    end

endmodule

/* rtl/evad_accum.sv */
// ----------------------------------------------------------------------------
// evad_accum
// Sample front end: input register, square, and per-frame energy and count
// accumulation that hands one frame record downstream on the last sample.
// ----------------------------------------------------------------------------
module evad_accum (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [evad_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 i_last_of_frame,
    input  logic                                 i_prob_valid,
    input  logic        [evad_pkg::PROB_W-1:0]   i_voice_prob,
    output logic                                 o_frame_valid,
    input  logic                                 i_frame_ready,
    output evad_pkg::t_frame                     o_frame
);

    // input stage
    logic                                 r_s1_valid;
    logic signed [evad_pkg::SAMPLE_W-1:0] r_s1_sample;
    logic                                 r_s1_last;
    logic                                 r_s1_pvalid;
    logic        [evad_pkg::PROB_W-1:0]   r_s1_prob;

    // square stage
    logic                                 r_s2_valid;
    logic        [evad_pkg::SQ_W-1:0]     r_s2_sq;
    logic                                 r_s2_last;
    logic                                 r_s2_pvalid;
    logic        [evad_pkg::PROB_W-1:0]   r_s2_prob;

    // frame accumulators and frame record
    logic        [evad_pkg::ACC_W-1:0]    r_acc;
    logic        [evad_pkg::CNT_W-1:0]    r_cnt;
    logic                                 r_fr_valid;
    evad_pkg::t_frame                     r_frame;

    logic        [evad_pkg::MAG_W-1:0]    w_mag;
    logic        [2*evad_pkg::MAG_W-1:0]  w_prod;
    logic        [evad_pkg::ACC_W-1:0]    n_acc;
    logic        [evad_pkg::CNT_W-1:0]    n_cnt;
    logic                                 w_fr_free;
    logic                                 w_s2_take;
    logic                                 w_s2_free;
    logic                                 w_s1_free;

    assign w_fr_free = !r_fr_valid || i_frame_ready;
    assign w_s2_take = r_s2_valid && (!r_s2_last || w_fr_free);
    assign w_s2_free = !r_s2_valid || w_s2_take;
    assign w_s1_free = !r_s1_valid || w_s2_free;
    assign o_ready   = w_s1_free;

    assign w_mag  = r_s1_sample[evad_pkg::SAMPLE_W-1]
                  ? (~{r_s1_sample[evad_pkg::SAMPLE_W-1], r_s1_sample}) + evad_pkg::MAG_W'(1)
                  : {1'b0, r_s1_sample};
    assign w_prod = w_mag * w_mag;

    always_comb begin
        if (r_cnt < evad_pkg::CNT_W'(evad_pkg::MAX_FRAME_SAMPLES)) begin
            n_acc = r_acc + evad_pkg::ACC_W'(r_s2_sq);
            n_cnt = r_cnt + evad_pkg::CNT_W'(1);
        end else begin
            n_acc = r_acc;
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_fr_valid <= 1'b0;
            r_acc      <= '0;
            r_cnt      <= '0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= i_valid;
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_fr_free) begin
                r_fr_valid <= w_s2_take && r_s2_last;
            end
            if (w_s2_take) begin
                if (r_s2_last) begin
                    r_acc <= '0;
                    r_cnt <= '0;
                end else begin
                    r_acc <= n_acc;
                    r_cnt <= n_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_free && i_valid) begin
            r_s1_sample <= i_sample;
            r_s1_last   <= i_last_of_frame;
            r_s1_pvalid <= i_prob_valid;
            r_s1_prob   <= i_voice_prob;
        end
        if (w_s2_free && r_s1_valid) begin
            r_s2_sq     <= w_prod[evad_pkg::SQ_W-1:0];
            r_s2_last   <= r_s1_last;
            r_s2_pvalid <= r_s1_pvalid;
            r_s2_prob   <= r_s1_prob;
        end
        if (w_s2_take && r_s2_last) begin
            r_frame.energy     <= n_acc;
            r_frame.count      <= n_cnt;
            r_frame.prob_valid <= r_s2_pvalid;
            r_frame.voice_prob <= r_s2_prob;
        end
    end

    assign o_frame_valid = r_fr_valid;
    assign o_frame       = r_frame;

endmodule

/* rtl/evad_decide.sv */
// ----------------------------------------------------------------------------
// evad_decide
// Frame decision: threshold product, voice decision, hangover and speaking
// state, and the result register.
// ----------------------------------------------------------------------------
module evad_decide (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  evad_pkg::t_cfg    i_cfg,
    input  logic              i_frame_valid,
    output logic              o_frame_ready,
    input  evad_pkg::t_frame  i_frame,
    output logic              o_valid,
    input  logic              i_ready,
    output evad_pkg::t_result o_result
);

    logic                          r_p_valid;
    evad_pkg::t_frame              r_p_frame;
    logic [evad_pkg::PROD_W-1:0]   r_p_limit;

    logic                          r_out_valid;
    evad_pkg::t_result             r_out;

    logic [evad_pkg::HANG_W-1:0]   r_hang;
    logic                          r_talking;

    logic                          w_out_free;
    logic                          w_p_free;
    logic                          w_p_move;
    logic [evad_pkg::PROD_W-1:0]   w_limit;
    logic                          w_voice;
    logic [evad_pkg::HANG_W-1:0]   n_hang;
    logic                          n_talking;
    logic                          w_changed;
    logic                          w_send;
    logic                          w_silence;
    logic [63:0]                   w_energy64;
    logic [63:0]                   w_count64;

    assign w_out_free    = !r_out_valid || i_ready;
    assign w_p_move      = r_p_valid && w_out_free;
    assign w_p_free      = !r_p_valid || w_out_free;
    assign o_frame_ready = w_p_free;

    assign w_limit = evad_pkg::PROD_W'(i_cfg.power_threshold)
                   * evad_pkg::PROD_W'(i_frame.count);

    always_comb begin
        if (i_cfg.use_prob_vad && r_p_frame.prob_valid) begin
            w_voice = r_p_frame.voice_prob > i_cfg.prob_threshold;
        end else begin
            w_voice = evad_pkg::PROD_W'(r_p_frame.energy) > r_p_limit;
        end

        n_hang    = r_hang;
        n_talking = r_talking;
        w_changed = 1'b0;
        w_silence = 1'b0;
        w_send    = 1'b0;
        if (w_voice) begin
            n_hang    = i_cfg.hangover_frames;
            n_talking = 1'b1;
            w_changed = !r_talking;
            w_send    = 1'b1;
        end else if (r_hang != '0) begin
            n_hang    = r_hang - evad_pkg::HANG_W'(1);
            w_send    = r_talking;
        end else if (r_talking) begin
            n_talking = 1'b0;
            w_changed = 1'b1;
            w_silence = 1'b1;
        end
    end

    assign w_energy64 = 64'(r_p_frame.energy);
    assign w_count64  = 64'(r_p_frame.count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_hang      <= '0;
            r_talking   <= 1'b0;
        end else begin
            if (w_p_free) begin
                r_p_valid <= i_frame_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_p_valid;
            end
            if (w_p_move) begin
                r_hang    <= n_hang;
                r_talking <= n_talking;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_free && i_frame_valid) begin
            r_p_frame <= i_frame;
            r_p_limit <= w_limit;
        end
        if (w_p_move) begin
            r_out.frame_energy     <= (w_energy64 > 64'(evad_pkg::ENERGY_MAX))
                                    ? evad_pkg::ENERGY_MAX
                                    : w_energy64[evad_pkg::ENERGY_W-1:0];
            r_out.frame_count      <= (w_count64 > 64'(evad_pkg::COUNT_OUT_MAX))
                                    ? evad_pkg::COUNT_OUT_MAX
                                    : w_count64[evad_pkg::COUNT_OUT_W-1:0];
            r_out.voice_detected   <= w_voice;
            r_out.speaking         <= n_talking;
            r_out.speaking_changed <= w_changed;
            r_out.send_frame       <= w_send;
            r_out.send_silence     <= w_silence;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

/* rtl/energy_vad_hangover_gate.sv */
// ----------------------------------------------------------------------------
// energy_vad_hangover_gate
// Energy voice activity detector with hangover-gated transmit decision.
// ----------------------------------------------------------------------------
// Takes one PCM sample per cycle with no gaps required; a result for a frame
// passes, after the transfer of its last sample, through the pipeline of
// input register, squarer, accumulator, threshold multiplier and result
// register. Each stage holds while the stage after it is full, so
// input stalls only once results back up through the whole pipeline.
// Samples past the frame length limit are ignored. Write registers only while
// no frame is in flight.
// ----------------------------------------------------------------------------
module energy_vad_hangover_gate (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic        [evad_pkg::ADDR_W-1:0]       paddr,
    input  logic        [evad_pkg::DATA_W-1:0]       pwdata,
    output logic        [evad_pkg::DATA_W-1:0]       prdata,
    output logic                                     pready,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic signed [evad_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic                                     i_last_of_frame,
    input  logic                                     i_prob_valid,
    input  logic        [evad_pkg::PROB_W-1:0]       i_voice_prob,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic        [evad_pkg::ENERGY_W-1:0]     o_frame_energy,
    output logic        [evad_pkg::COUNT_OUT_W-1:0]  o_frame_count,
    output logic                                     o_voice_detected,
    output logic                                     o_speaking,
    output logic                                     o_speaking_changed,
    output logic                                     o_send_frame,
    output logic                                     o_send_silence
);

    evad_pkg::t_cfg    w_cfg;
    evad_pkg::t_frame  w_frame;
    logic              w_frame_valid;
    logic              w_frame_ready;
    evad_pkg::t_result w_result;

    evad_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    evad_accum u_accum (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample        (i_sample),
        .i_last_of_frame (i_last_of_frame),
        .i_prob_valid    (i_prob_valid),
        .i_voice_prob    (i_voice_prob),
        .o_frame_valid   (w_frame_valid),
        .i_frame_ready   (w_frame_ready),
        .o_frame         (w_frame)
    );

    evad_decide u_decide (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_frame_valid (w_frame_valid),
        .o_frame_ready (w_frame_ready),
        .i_frame       (w_frame),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result      (w_result)
    );

    assign o_frame_energy     = w_result.frame_energy;
    assign o_frame_count      = w_result.frame_count;
    assign o_voice_detected   = w_result.voice_detected;
    assign o_speaking         = w_result.speaking;
    assign o_speaking_changed = w_result.speaking_changed;
    assign o_send_frame       = w_result.send_frame;
    assign o_send_silence     = w_result.send_silence;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the energy voice activity detector with hangover
// gate. Frames of PCM samples go in over a valid/ready channel while both
// sides idle at random. A bench-side model of the frame energy, the voice
// decision and the hangover gate predicts each frame result, which is checked
// field by field against the transfers on the result channel. Registers are
// rewritten over the APB port between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import evad_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [ADDR_W-1:0]          paddr = '0;
    logic [DATA_W-1:0]          pwdata = '0;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       i_last_of_frame = 1'b0;
    logic                       i_prob_valid = 1'b0;
    logic [PROB_W-1:0]          i_voice_prob = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [ENERGY_W-1:0]        o_frame_energy;
    logic [COUNT_OUT_W-1:0]     o_frame_count;
    logic                       o_voice_detected;
    logic                       o_speaking;
    logic                       o_speaking_changed;
    logic                       o_send_frame;
    logic                       o_send_silence;

    energy_vad_hangover_gate dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_sample           (i_sample),
        .i_last_of_frame    (i_last_of_frame),
        .i_prob_valid       (i_prob_valid),
        .i_voice_prob       (i_voice_prob),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_frame_energy     (o_frame_energy),
        .o_frame_count      (o_frame_count),
        .o_voice_detected   (o_voice_detected),
        .o_speaking         (o_speaking),
        .o_speaking_changed (o_speaking_changed),
        .o_send_frame       (o_send_frame),
        .o_send_silence     (o_send_silence)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // bench copy of the registers and the detector state
    logic [PTHR_W-1:0] cfg_power = POWER_THRESHOLD_RST;
    logic [HANG_W-1:0] cfg_hang = HANGOVER_FRAMES_RST;
    logic              cfg_use_prob = USE_PROB_VAD_RST;
    logic [PROB_W-1:0] cfg_prob_thr = PROB_THRESHOLD_RST;
    logic [63:0]       acc_energy = '0;
    int                acc_samples = 0;
    logic [HANG_W-1:0] hang_left = '0;
    logic              talk_on = 1'b0;

    t_result pending_results[$];

    int src_gap_max = 16;
    int sink_gap_max = 16;
    int mismatches = 0;
    int samples_sent = 0;
    int frames_checked = 0;
    int voiced_frames = 0;
    int silence_requests = 0;
    int idle_cycles = 0;

    task automatic vad_predict(input logic signed [SAMPLE_W-1:0] s, input logic last,
                               input logic pv, input logic [PROB_W-1:0] pr);
        longint  mag;
        logic    voice;
        t_result r;
        mag = s;
        if (mag < 0) mag = -mag;
        if (acc_samples < MAX_FRAME_SAMPLES) begin
            acc_energy += 64'(mag * mag);
            acc_samples++;
        end
        if (last) begin
            r = '0;
            if (cfg_use_prob && pv) voice = pr > cfg_prob_thr;
            else voice = acc_energy > 64'(cfg_power) * 64'(acc_samples);
            r.voice_detected = voice;
            if (voice) begin
                hang_left = cfg_hang;
                if (!talk_on) begin
                    talk_on = 1'b1;
                    r.speaking_changed = 1'b1;
                end
                r.send_frame = 1'b1;
            end else if (hang_left != 0) begin
                hang_left--;
                r.send_frame = talk_on;
            end else if (talk_on) begin
                talk_on = 1'b0;
                r.speaking_changed = 1'b1;
                r.send_silence = 1'b1;
            end
            r.speaking = talk_on;
            r.frame_energy = (acc_energy > 64'(ENERGY_MAX)) ? ENERGY_MAX
                                                            : acc_energy[ENERGY_W-1:0];
            r.frame_count = (acc_samples > int'(COUNT_OUT_MAX)) ? COUNT_OUT_MAX
                                                                : COUNT_OUT_W'(acc_samples);
            pending_results.push_back(r);
            acc_energy = '0;
            acc_samples = 0;
        end
    endtask

    function automatic string fmt_result(input t_result r);
        return $sformatf({"energy=%0d count=%0d voice=%0b speaking=%0b changed=%0b",
                          " send=%0b silence=%0b"},
                         r.frame_energy, r.frame_count, r.voice_detected, r.speaking,
                         r.speaking_changed, r.send_frame, r.send_silence);
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_POWER_THRESHOLD: cfg_power = val[PTHR_W-1:0];
            REG_HANGOVER_FRAMES: cfg_hang = val[HANG_W-1:0];
            REG_USE_PROB_VAD:    cfg_use_prob = val[0];
            REG_PROB_THRESHOLD:  cfg_prob_thr = val[PROB_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last,
                               input logic pv, input logic [PROB_W-1:0] pr);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_sample        <= s;
        i_last_of_frame <= last;
        i_prob_valid    <= pv;
        i_voice_prob    <= pr;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        vad_predict(s, last, pv, pr);
        samples_sent++;
    endtask

    // flat frames use +-amp, others spread uniformly in +-amp; positives clip at 32767
    task automatic send_frame(input int len, input int amp, input bit flat,
                              input logic pv, input logic [PROB_W-1:0] pr);
        int  v;
        for (int k = 0; k < len; k++) begin
            if (flat) v = ($urandom_range(0, 1) != 0) ? amp : -amp;
            else v = int'($urandom_range(0, 2 * amp)) - amp;
            if (v > 32767) v = 32767;
            if (k == len - 1) send_sample(SAMPLE_W'(v), 1'b1, pv, pr);
            else send_sample(SAMPLE_W'(v), 1'b0, 1'($urandom), PROB_W'($urandom));
        end
    endtask

    // drop valid, drain all results, let the pipeline empty
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic test_reset_config();
        src_gap_max = 16;
        sink_gap_max = 16;
        send_sample(16'sd0, 1'b1, 1'b0, 8'd0);
        send_sample(16'sd32767, 1'b0, 1'b1, 8'hFF);
        send_sample(-16'sd32768, 1'b1, 1'b1, 8'hFF);
        send_frame(4, 100, 1'b1, 1'b1, 8'd200);
        send_frame(2, 101, 1'b1, 1'b0, 8'd0);
    endtask

    task automatic test_talk_end();
        settle();
        write_reg(REG_HANGOVER_FRAMES, 32'd0);
        send_frame(1, 1000, 1'b1, 1'b0, 8'd0);
        send_frame(3, 0, 1'b1, 1'b0, 8'd0);
        send_frame(1, 0, 1'b1, 1'b0, 8'd0);
        send_frame(1, 1000, 1'b1, 1'b0, 8'd0);
        send_frame(1, 10, 1'b0, 1'b0, 8'd0);
    endtask

    task automatic test_prob_select();
        settle();
        write_reg(REG_USE_PROB_VAD, 32'd1);
        write_reg(REG_PROB_THRESHOLD, 32'd128);
        send_sample(16'sd0, 1'b1, 1'b1, 8'd129);
        send_sample(16'sd32767, 1'b1, 1'b1, 8'd128);
        send_sample(16'sd32767, 1'b1, 1'b0, 8'd0);
        send_sample(16'sd0, 1'b1, 1'b1, 8'd255);
    endtask

    // full-scale frames back to back; energy lands exactly on threshold
    task automatic test_long_frame();
        settle();
        write_reg(REG_POWER_THRESHOLD, 32'd1073741824);
        write_reg(REG_USE_PROB_VAD, 32'd0);
        src_gap_max = 0;
        sink_gap_max = 0;
        for (int k = 0; k < 64; k++)
            send_sample(-16'sd32768, k == 63, 1'b0, 8'd0);
        send_sample(-16'sd32768, 1'b1, 1'b0, 8'd0);
    endtask

    task automatic test_random_traffic(input int n_items, input logic [PTHR_W-1:0] pthr,
                                       input logic [HANG_W-1:0] hang, input logic use_prob,
                                       input logic [PROB_W-1:0] prob_thr, input int src_max,
                                       input int sink_max);
        int                sent;
        int                len;
        int                root;
        int                amp;
        bit                flat;
        logic              pv;
        logic [PROB_W-1:0] pr;
        settle();
        write_reg(REG_POWER_THRESHOLD, DATA_W'(pthr));
        write_reg(REG_HANGOVER_FRAMES, DATA_W'(hang));
        write_reg(REG_USE_PROB_VAD, DATA_W'(use_prob));
        write_reg(REG_PROB_THRESHOLD, DATA_W'(prob_thr));
        src_gap_max = src_max;
        sink_gap_max = sink_max;
        root = int'($sqrt(real'(pthr)));
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200)
                                               : $urandom_range(1, 24);
            case ($urandom_range(0, 6))
                0: amp = 0;
                1: amp = root / 2;
                2: amp = root;
                3: amp = root + 1;
                4: amp = 2 * root;
                5: amp = 32768;
                default: amp = $urandom_range(0, 32768);
            endcase
            if (amp > 32768) amp = 32768;
            flat = $urandom_range(0, 1);
            pv = $urandom_range(0, 1);
            if ($urandom_range(0, 2) == 0) pr = prob_thr + PROB_W'($urandom_range(0, 1));
            else pr = PROB_W'($urandom);
            send_frame(len, amp, flat, pv, pr);
            sent += len;
        end
    endtask

    // result side: random stall before each transfer
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, sink_gap_max);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_frame_energy, o_frame_count, o_voice_detected, o_speaking,
                    o_speaking_changed, o_send_frame, o_send_silence};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %s", fmt_result(got));
            end else begin
                want = pending_results.pop_front();
                frames_checked++;
                if (want.voice_detected) voiced_frames++;
                if (want.send_silence) silence_requests++;
                if (got.frame_energy !== want.frame_energy
                        || got.frame_count !== want.frame_count
                        || got.voice_detected !== want.voice_detected
                        || got.speaking !== want.speaking
                        || got.speaking_changed !== want.speaking_changed
                        || got.send_frame !== want.send_frame
                        || got.send_silence !== want.send_silence) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("frame %0d mismatch", frames_checked);
                        $display("  expected %s", fmt_result(want));
                        $display("  actual   %s", fmt_result(got));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_config();
        test_talk_end();
        test_prob_select();
        test_long_frame();
        test_random_traffic(300, 31'd10000, 10'd2, 1'b0, 8'd128, 16, 16);
        test_random_traffic(300, 31'd0, 10'd0, 1'b1, 8'd0, 0, 0);
        test_random_traffic(300, 31'd1073741824, 10'd1023, 1'b1, 8'd255, 3, 16);
        test_random_traffic(300, PTHR_W'($urandom_range(0, 50000)),
                            HANG_W'($urandom_range(0, 5)), 1'b1, PROB_W'($urandom), 16, 0);
        test_random_traffic(300, PTHR_W'($urandom_range(1, 1073741824)),
                            HANG_W'($urandom_range(0, 20)), 1'b0, PROB_W'($urandom), 3, 3);
        test_random_traffic(350, 31'd9, 10'd1, 1'b0, 8'd64, 16, 16);
        settle();
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", pending_results.size());
        end
        $display("Sent %0d samples; checked %0d frame results", samples_sent, frames_checked);
        $display("(%0d voiced, %0d talk-end requests), mismatches: %0d",
                 voiced_frames, silence_requests, mismatches);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
